### design/knn_pkg.sv
// Shared types and constants for the k-th nearest neighbor tracker.
// No dependencies.
package knn_pkg;

	localparam int SQ_W   = 34;
	localparam int ROOT_W = 17;
	localparam int CNT_W  = 7;
	localparam int ID_W   = 16;

	localparam logic [SQ_W-1:0] SQ_MAX = {SQ_W{1'b1}};

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	localparam logic [2:0] REG_K_RANK = 3'd0;
	localparam logic [2:0] REG_OWN_X0 = 3'd1;
	localparam logic [2:0] REG_OWN_X3 = 3'd4;

	localparam logic OP_ADD = 1'b0;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIST,
		S_SCAN,
		S_SHIFT,
		S_PLACE,
		S_TRACK,
		S_TRACK_RD,
		S_ROOT,
		S_OUT
	} seq_state_t;

endpackage

### design/knn_sqrt.sv
// Iterative floor square root, one result bit per step, one step a cycle.
// Depends on knn_pkg.
module knn_sqrt
	import knn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   value,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_W+1:0] rem_q;
	logic [SQ_W+1:0] res_q;
	logic [SQ_W+1:0] bit_q;
	logic            busy_q;
	logic [SQ_W+1:0] trial;

	assign trial = res_q + bit_q;
	assign done  = busy_q && (bit_q == '0);
	assign root  = res_q[ROOT_W-1:0];

	// Run the shift-subtract recurrence, one bit pair per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {2'b00, value};
			res_q <= '0;
			bit_q <= {2'b01, {SQ_W{1'b0}}};
		end else if (busy_q && bit_q != '0) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

### design/kth_nearest_neighbor_tracker.sv
// Top level: sorted neighbor table, distance sequencer and root unit.
// Depends on knn_pkg and knn_sqrt.
//
// channel   | dir | contents
// s_axis    | in  | operation, neighbor_id, nb_x0..nb_x3
// m_axis    | out | kth_sq_dist, kth_dist, has_kth, neighbor_count, status
// cfg       | in  | k_rank, own_x0..own_x3
//
// One word passes through acceptance, distance accumulation over the DIM
// coordinates, the table scan, the shift of the entries behind the insert
// or remove point, placement, the tracked read, the root and the result
// output. The table is a simple dual-port memory read once a cycle, which
// sets the scan and shift length.
// Reset clears count and control; table contents are undefined until written.
// The input is not ready while a word is in work or a result waits.
module kth_nearest_neighbor_tracker
	import knn_pkg::*;
#(
	parameter int MAX_NEIGHBORS = 64,
	parameter int DIM           = 4,
	parameter int COORD_BITS    = 16
)(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// operation, neighbor_id, nb_x0..nb_x3 (COORD_BITS each), zero pad
	input  logic [((1+ID_W+4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// kth_sq_dist, kth_dist, has_kth, neighbor_count, status, zero pad
	output logic [63:0]            m_axis_tdata,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [15:0]            cfg_wdata
);

	localparam int AW    = $clog2(MAX_NEIGHBORS);
	localparam int NW    = $clog2(MAX_NEIGHBORS+1);
	localparam int DW    = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int ENT_W = SQ_W + ID_W;

	// Configuration
	logic [CNT_W-1:0]      k_rank_q;
	logic [COORD_BITS-1:0] own_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_rank_q <= CNT_W'(1);
			for (int i = 0; i < 4; i++) own_q[i] <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_K_RANK) begin
				k_rank_q <= cfg_wdata[CNT_W-1:0];
			end else if (cfg_index >= REG_OWN_X0 && cfg_index <= REG_OWN_X3) begin
				own_q[2'(cfg_index - REG_OWN_X0)] <= cfg_wdata[COORD_BITS-1:0];
			end
		end
	end

	// Table memory: one write port, one registered read port
	logic [ENT_W-1:0] mem [MAX_NEIGHBORS];
	logic             mem_we;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	logic [ENT_W-1:0] mem_wdata, mem_rdata_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		mem_rdata_q <= mem[mem_raddr];
	end

	// Sequencer state
	seq_state_t              state_q, state_d;
	logic                    op_q;
	logic [ID_W-1:0]         id_q;
	logic [COORD_BITS-1:0]   nb_q [4];
	logic [DW-1:0]           dim_q;
	logic [SQ_W+1:0]         acc_q;
	logic [SQ_W-1:0]         dist_q;
	logic [NW-1:0]           count_q;
	logic [NW-1:0]           ptr_q;
	logic [NW-1:0]           pos_q;
	logic                    rd_pend_q;
	logic [1:0]              status_q;
	logic [SQ_W-1:0]         track_q;
	logic                    has_q;
	logic                    out_valid_q;
	logic [SQ_W-1:0]         out_sq_q;
	logic [ROOT_W-1:0]       out_root_q;

	// Shared difference-square unit
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]        adiff;
	logic [2*DIFF_W-1:0]      sq;
	assign diff  = DIFF_W'(signed'(own_q[2'(dim_q)])) - DIFF_W'(signed'(nb_q[2'(dim_q)]));
	assign adiff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
	assign sq    = adiff * adiff;

	// Root unit
	logic              sq_start, sq_done;
	logic [ROOT_W-1:0] sq_root;
	logic [SQ_W-1:0]   track_d;

	knn_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (track_d),
		.done   (sq_done),
		.root   (sq_root)
	);

	logic [SQ_W-1:0] rd_dist;
	logic [ID_W-1:0] rd_id;
	logic [NW-1:0]   k_eff;
	assign rd_dist = mem_rdata_q[ENT_W-1:ID_W];
	assign rd_id   = mem_rdata_q[ID_W-1:0];
	assign track_d = (count_q == '0) ? '0 : rd_dist;
	assign k_eff   = (k_rank_q == '0) ? NW'(1) :
		((NW'(k_rank_q) > count_q || k_rank_q > CNT_W'(MAX_NEIGHBORS)) ? count_q
		: NW'(k_rank_q));

	assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, status_q, CNT_W'(count_q), has_q, out_root_q, out_sq_q};

	// Next state and memory control
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = ptr_q[AW-1:0];
		mem_wdata = mem_rdata_q;
		mem_raddr = ptr_q[AW-1:0];
		sq_start  = 1'b0;
		case (state_q)
			S_IDLE: if (s_axis_tvalid && s_axis_tready) state_d = S_DIST;
			S_DIST: if (dim_q == DW'(DIM-1)) begin
				// a full table skips the scan and reports the unchanged state
				state_d = (op_q == OP_ADD && count_q == NW'(MAX_NEIGHBORS)) ? S_TRACK
					: S_SCAN;
			end
			S_SCAN: begin
				if (rd_pend_q) begin
					if (op_q == OP_ADD) begin
						if (rd_dist > dist_q) state_d = S_SHIFT;
					end else if (rd_id == id_q && rd_dist == dist_q) begin
						state_d = S_SHIFT;
					end
				end
				if (!rd_pend_q || state_d == S_SCAN) begin
					if (ptr_q == count_q && !(rd_pend_q && state_d != S_SCAN))
						state_d = (op_q == OP_ADD) ? S_PLACE : S_TRACK;
				end
			end
			S_SHIFT: begin
				// add: ptr walks down, copy [ptr-1] to [ptr]; remove: copy [ptr+1] to [ptr]
				if (op_q == OP_ADD) begin
					mem_raddr = AW'(ptr_q - NW'(1));
					if (rd_pend_q) begin
						mem_we = 1'b1;
						mem_waddr = AW'(ptr_q);
					end
					if (ptr_q == pos_q) state_d = S_PLACE;
				end else begin
					mem_raddr = AW'(ptr_q + NW'(1));
					if (rd_pend_q) begin
						mem_we = 1'b1;
						mem_waddr = AW'(ptr_q);
					end
					if (ptr_q + NW'(1) >= count_q) state_d = S_TRACK;
				end
			end
			S_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q[AW-1:0];
				mem_wdata = {dist_q, id_q};
				state_d   = S_TRACK;
			end
			S_TRACK: begin
				mem_raddr = AW'(k_eff - NW'(1));
				state_d   = S_TRACK_RD;
			end
			S_TRACK_RD: begin
				sq_start = 1'b1;
				state_d  = S_ROOT;
			end
			S_ROOT: if (sq_done) state_d = S_OUT;
			S_OUT:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// State register and control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			has_q       <= 1'b0;
			out_valid_q <= 1'b0;
			rd_pend_q   <= 1'b0;
			ptr_q       <= '0;
			pos_q       <= '0;
			dim_q       <= '0;
			status_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					dim_q <= '0;
					ptr_q <= '0;
					rd_pend_q <= 1'b0;
					// hold the status of a waiting result until the next word
					if (state_d == S_DIST) status_q <= ST_OK;
				end
				S_DIST: begin
					dim_q <= dim_q + DW'(1);
					if (state_d == S_TRACK) status_q <= ST_FULL;
				end
				S_SCAN: begin
					if (state_d == S_SHIFT) begin
						if (op_q == OP_ADD) begin
							pos_q <= ptr_q - NW'(1);
							ptr_q <= count_q;
						end else begin
							ptr_q <= ptr_q - NW'(1);
						end
						rd_pend_q <= 1'b0;
					end else if (state_d == S_PLACE) begin
						pos_q <= count_q;
					end else if (state_d == S_TRACK) begin
						status_q <= ST_NOTFOUND;
					end else if (ptr_q != count_q) begin
						ptr_q <= ptr_q + NW'(1);
						rd_pend_q <= 1'b1;
					end
				end
				S_SHIFT: begin
					if (op_q == OP_ADD) begin
						if (ptr_q != pos_q) begin
							if (rd_pend_q) begin
								ptr_q <= ptr_q - NW'(1);
								rd_pend_q <= 1'b0;
							end else begin
								rd_pend_q <= 1'b1;
							end
						end
					end else begin
						if (rd_pend_q) begin
							ptr_q <= ptr_q + NW'(1);
							rd_pend_q <= 1'b0;
						end else begin
							rd_pend_q <= 1'b1;
						end
						if (state_d == S_TRACK) count_q <= count_q - NW'(1);
					end
				end
				S_PLACE: count_q <= count_q + NW'(1);
				S_TRACK_RD: has_q <= (count_q != '0);
				S_OUT: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_q  <= s_axis_tdata[0];
			id_q  <= s_axis_tdata[ID_W:1];
			for (int i = 0; i < 4; i++)
				nb_q[i] <= s_axis_tdata[1+ID_W+i*COORD_BITS +: COORD_BITS];
			acc_q <= '0;
		end
		if (state_q == S_DIST) begin
			if (dim_q == DW'(DIM-1))
				dist_q <= ((acc_q + (SQ_W+2)'(sq)) > (SQ_W+2)'(SQ_MAX)) ? SQ_MAX
					: SQ_W'(acc_q + (SQ_W+2)'(sq));
			else
				acc_q <= acc_q + (SQ_W+2)'(sq);
		end
		if (state_q == S_TRACK_RD)
			track_q <= track_d;
		if (state_q == S_ROOT && sq_done) begin
			out_sq_q   <= track_q;
			out_root_q <= sq_root;
		end
	end

endmodule
